// ----- rtl/sat_pkg.sv -----
// sat_pkg: shared types and constants of the shell argument tokenizer.
// Depends on nothing; sat_lexer and shell_argument_tokenizer take names from here.
`default_nettype none

package sat_pkg;

  // Lexer states; saved state uses the same encoding
  typedef enum logic [1:0] {
    LEX_WS     = 2'd0,
    LEX_TOKEN  = 2'd1,
    LEX_STRING = 2'd2,
    LEX_ESCAPE = 2'd3
  } lex_state_e;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Width of the reported argument number and count
  localparam int unsigned ArgW = 3;

  // One result word
  typedef struct packed {
    logic [7:0]      out_char;
    logic            arg_start;
    logic [ArgW-1:0] arg_index;
    logic            command_end;
    logic [ArgW-1:0] arg_count;
    logic            overflow;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/sat_byte_if.sv -----
// sat_byte_if: valid/ready channel carrying one command-line byte per word.
// Depends on nothing.
`default_nettype none

interface sat_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// ----- rtl/sat_tok_if.sv -----
// sat_tok_if: valid/ready channel carrying one tokenizer result per word.
// Depends on nothing; field widths follow sat_pkg::tok_t.
`default_nettype none

interface sat_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       arg_start;
  logic [2:0] arg_index;
  logic       command_end;
  logic [2:0] arg_count;
  logic       overflow;

  modport source (output valid, output out_char, output arg_start, output arg_index,
                  output command_end, output arg_count, output overflow, input ready);
  modport sink   (input valid, input out_char, input arg_start, input arg_index,
                  input command_end, input arg_count, input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/sat_lexer.sv -----
// sat_lexer: tokenizer state registers and the per-byte decode and update logic.
// Depends on sat_pkg (lexer states, character codes, result struct).
`default_nettype none

module sat_lexer #(
  parameter int unsigned MAX_ARGS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic [7:0]  ch_i,
  output sat_pkg::tok_t    tok_o
);

  localparam int unsigned CntW = $clog2(MAX_ARGS + 1);
  localparam logic [CntW-1:0] MaxArgs = CntW'(MAX_ARGS);

  sat_pkg::lex_state_e state_q, state_d, saved_q, saved_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_step;
  logic            pend_q, pend_d;
  logic            ovf_q, ovf_d, ovf_step;

  logic is_end, is_blank, is_quote, is_bslash, in_plain;
  logic claim_req, claim_ok, claim_win;
  logic [CntW-1:0] idx_raw;
  logic [CntW+sat_pkg::ArgW-1:0] idx_ext, cnt_ext;

  // Classify the byte against the current state
  always_comb begin
    is_blank  = (ch_i == sat_pkg::CH_SPACE) || (ch_i == sat_pkg::CH_TAB);
    is_quote  = (ch_i == sat_pkg::CH_QUOTE);
    is_bslash = (ch_i == sat_pkg::CH_BSLASH);
    in_plain  = (state_q == sat_pkg::LEX_WS) || (state_q == sat_pkg::LEX_TOKEN);
    is_end    = (ch_i == sat_pkg::CH_NUL) || ((ch_i == sat_pkg::CH_SEMI) && in_plain);
    claim_req = !is_end && in_plain &&
                (is_quote || ((state_q == sat_pkg::LEX_WS) && !is_blank && !is_bslash));
    claim_ok  = (cnt_q != MaxArgs);
    claim_win = claim_req && claim_ok;
    cnt_step  = claim_win ? cnt_q + CntW'(1) : cnt_q;
    ovf_step  = ovf_q | (claim_req & ~claim_ok);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    saved_d = saved_q;
    pend_d  = 1'b0;
    cnt_d   = cnt_step;
    ovf_d   = ovf_step;
    if (is_end) begin
      state_d = sat_pkg::LEX_WS;
      saved_d = sat_pkg::LEX_WS;
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      unique case (state_q)
        sat_pkg::LEX_ESCAPE: state_d = saved_q;
        sat_pkg::LEX_STRING: begin
          if (is_quote) state_d = sat_pkg::LEX_WS;
        end
        sat_pkg::LEX_WS, sat_pkg::LEX_TOKEN: begin
          if (is_blank) begin
            state_d = sat_pkg::LEX_WS;
          end else if (is_quote) begin
            state_d = sat_pkg::LEX_STRING;
            pend_d  = claim_ok;
          end else if (is_bslash) begin
            saved_d = state_q;
            state_d = sat_pkg::LEX_ESCAPE;
          end else begin
            state_d = sat_pkg::LEX_TOKEN;
          end
        end
        default: state_d = sat_pkg::LEX_WS;
      endcase
    end
  end

  // Result word for this byte
  always_comb begin
    idx_raw = pend_q ? cnt_q - CntW'(1) : cnt_q;
    idx_ext = {{sat_pkg::ArgW{1'b0}}, idx_raw};
    cnt_ext = {{sat_pkg::ArgW{1'b0}}, cnt_step};
    tok_o.arg_start   = pend_q || (claim_win && !is_quote);
    tok_o.arg_index   = tok_o.arg_start ? idx_ext[sat_pkg::ArgW-1:0] : '0;
    tok_o.command_end = is_end;
    tok_o.arg_count   = cnt_ext[sat_pkg::ArgW-1:0];
    tok_o.overflow    = ovf_step;
    if (is_end || (in_plain && (is_blank || is_quote)) ||
        ((state_q == sat_pkg::LEX_STRING) && is_quote)) begin
      tok_o.out_char = '0;
    end else begin
      tok_o.out_char = ch_i;
    end
  end

  // Advance state once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sat_pkg::LEX_WS;
      saved_q <= sat_pkg::LEX_WS;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (advance_i) begin
      state_q <= state_d;
      saved_q <= saved_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ovf_q   <= ovf_d;
    end
  end

  // A pending start only ever waits inside a string
  a_pend_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == sat_pkg::LEX_STRING && cnt_q != '0))
    else $error("start pending outside a string");

  // Count never passes the limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxArgs)
    else $error("argument count beyond limit");

  // Overflow only once the count is full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == MaxArgs))
    else $error("overflow with room left");

  // Escape never saves itself
  a_saved_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (saved_q == sat_pkg::LEX_WS) || (saved_q == sat_pkg::LEX_TOKEN))
    else $error("saved state is not plain");

  // Command end leaves everything at its idle values
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && is_end) |=> (state_q == sat_pkg::LEX_WS && cnt_q == '0 && !ovf_q))
    else $error("command end did not clear state");

endmodule

`default_nettype wire

// ----- rtl/shell_argument_tokenizer.sv -----
// shell_argument_tokenizer: input byte register, lexer, result register.
// Depends on sat_pkg, sat_byte_if, sat_tok_if and sat_lexer.
//
//   channel  dir  modport  word
//   in_i     in   sink     ch: one command-line byte
//   out_o    out  source   out_char, arg_start, arg_index, command_end,
//                          arg_count, overflow
//
// One byte per cycle sustained while out_o.ready stays high; a byte's result is
// registered: the byte waits in the input register, then the lexer update loads
// the result register, from which out_o presents it.
// The lexer state moves only when a byte passes from the input to the result register,
// so stalls on out_o freeze the lexer and hold the result and any byte already held.
// in_i.ready stays high while the input register is empty or draining.
// Reset (rst_ni low, asynchronous) empties both registers and returns the lexer
// to whitespace with a zero argument count.
`default_nettype none

module shell_argument_tokenizer #(
  parameter int unsigned MAX_ARGS = 7
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  sat_byte_if.sink   in_i,
  sat_tok_if.source  out_o
);

  logic          in_valid_q;
  logic [7:0]    in_ch_q;
  logic          out_valid_q;
  sat_pkg::tok_t tok_q, tok_d;
  logic          advance;

  // Move a byte on when the result register is free or being taken
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  sat_lexer #(
    .MAX_ARGS (MAX_ARGS)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ch_i      (in_ch_q),
    .tok_o     (tok_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_ch_q <= in_i.ch;
    if (advance) tok_q <= tok_d;
  end

  // Drive the result channel
  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = tok_q.out_char;
  assign out_o.arg_start   = tok_q.arg_start;
  assign out_o.arg_index   = tok_q.arg_index;
  assign out_o.command_end = tok_q.command_end;
  assign out_o.arg_count   = tok_q.arg_count;
  assign out_o.overflow    = tok_q.overflow;

  // A held byte with a free result register always moves on
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> advance)
    else $error("byte held while result register free");

  // A result only appears after a byte was moved on
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result without a byte");

  // The input register is never overwritten while still full and stuck
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_ch_q)))
    else $error("held byte lost");

endmodule

`default_nettype wire
